### sv/imts_pkg.sv
package imts_pkg;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_TX   = 2'd1,
		MODE_RX   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		PH_ADDR = 2'd0,
		PH_LEN  = 2'd1,
		PH_DATA = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		FIN_NONE    = 3'd0,
		FIN_DONE    = 3'd1,
		FIN_NAK     = 3'd2,
		FIN_HW      = 3'd3,
		FIN_INVALID = 3'd4,
		FIN_BUSY    = 3'd5
	} finish_t;

	localparam logic [1:0] CMD_START_RD = 2'd0;
	localparam logic [1:0] CMD_START_WR = 2'd1;
	localparam logic [1:0] CMD_EVENT    = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		logic [6:0] slave_addr;
		logic       use_addr;
		logic       use_len;
		logic [7:0] reg_addr;
		logic [7:0] length;
		logic       txis;
		logic       tc;
		logic       tcr;
		logic       rxne;
		logic       bus_fault;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic       program_res;
		logic [7:0] nbytes;
		logic       rd_wrn;
		logic       reload;
		logic       autoend;
		logic       gen_start;
		logic [6:0] slave_out;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       buf_valid;
		logic [7:0] buf_index;
		finish_t    finish_code;
	} out_item_t;

endpackage

### sv/imts_if.sv
interface imts_in_if import imts_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface imts_out_if import imts_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/i2c_master_transaction_sequencer.sv
// Pipeline: each item passes through the input register, then the result register.
// Throughput: one item per cycle while rsp.ready holds; the phase machine state updates as
// an item leaves the input register, so the next item sees it in the following cycle.
// Reset (arst_n low, asynchronous): mode idle, phase ADDR, counters and saved
// transfer fields zero, both pipeline registers empty.
module i2c_master_transaction_sequencer
	import imts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	imts_in_if.sink   req,
	imts_out_if.source rsp
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t res_s2;
	logic      advance;

	mode_t      mode_q, mode_n;
	phase_t     phase_q, phase_n;
	logic [7:0] byte_index_q, byte_index_n;
	logic [7:0] total_bytes_q, total_bytes_n;
	logic [7:0] saved_reg_addr_q, saved_reg_addr_n;
	logic       saved_use_len_q, saved_use_len_n;
	logic [6:0] saved_slave_q, saved_slave_n;
	out_item_t  res;
	logic [7:0] idx_inc;
	logic       is_rd;

	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign rsp.valid = valid_s2;
	assign rsp.data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready)
				valid_s1 <= req.valid;
			if (!valid_s2 || rsp.ready)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready)
			item_s1 <= req.data;
		if (advance)
			res_s2 <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q           <= MODE_IDLE;
			phase_q          <= PH_ADDR;
			byte_index_q     <= '0;
			total_bytes_q    <= '0;
			saved_reg_addr_q <= '0;
			saved_use_len_q  <= 1'b0;
			saved_slave_q    <= '0;
		end else if (advance) begin
			mode_q           <= mode_n;
			phase_q          <= phase_n;
			byte_index_q     <= byte_index_n;
			total_bytes_q    <= total_bytes_n;
			saved_reg_addr_q <= saved_reg_addr_n;
			saved_use_len_q  <= saved_use_len_n;
			saved_slave_q    <= saved_slave_n;
		end
	end

	assign idx_inc = byte_index_q + 8'd1;
	assign is_rd   = (item_s1.command == CMD_START_RD);

	always_comb begin
		mode_n           = mode_q;
		phase_n          = phase_q;
		byte_index_n     = byte_index_q;
		total_bytes_n    = total_bytes_q;
		saved_reg_addr_n = saved_reg_addr_q;
		saved_use_len_n  = saved_use_len_q;
		saved_slave_n    = saved_slave_q;
		res              = '0;

		case (item_s1.command)
			CMD_START_RD, CMD_START_WR: begin
				if (mode_q != MODE_IDLE) begin
					res.finish_code = FIN_BUSY;
				end else begin
					saved_slave_n    = item_s1.slave_addr;
					saved_reg_addr_n = item_s1.reg_addr;
					saved_use_len_n  = item_s1.use_len;
					total_bytes_n    = item_s1.length;
					byte_index_n     = '0;
					mode_n           = is_rd ? MODE_RX : MODE_TX;
					res.program_res  = 1'b1;
					res.gen_start    = 1'b1;
					res.slave_out    = item_s1.slave_addr;
					priority if (item_s1.use_addr) begin
						// register address always goes out as a write
						phase_n     = PH_ADDR;
						res.nbytes  = 8'd1;
						res.reload  = !is_rd;
					end else if (item_s1.use_len) begin
						phase_n     = PH_LEN;
						res.nbytes  = 8'd1;
						res.rd_wrn  = is_rd;
						res.reload  = 1'b1;
					end else begin
						phase_n     = PH_DATA;
						res.nbytes  = item_s1.length;
						res.rd_wrn  = is_rd;
						res.autoend = 1'b1;
					end
				end
			end
			CMD_EVENT: begin
				if (item_s1.bus_fault) begin
					res.finish_code = FIN_HW;
					mode_n          = MODE_IDLE;
				end else if (mode_q == MODE_TX) begin
					case (phase_q)
						PH_ADDR: begin
							priority if (item_s1.txis) begin
								res.tx_valid = 1'b1;
								res.tx_byte  = saved_reg_addr_q;
							end else if (item_s1.tcr) begin
								res.program_res = 1'b1;
								res.slave_out   = saved_slave_q;
								if (saved_use_len_q) begin
									phase_n     = PH_LEN;
									res.nbytes  = 8'd1;
									res.reload  = 1'b1;
								end else begin
									phase_n     = PH_DATA;
									res.nbytes  = total_bytes_q;
									res.autoend = 1'b1;
								end
							end else begin
								res.finish_code = FIN_NAK;
								mode_n          = MODE_IDLE;
							end
						end
						PH_LEN: begin
							priority if (item_s1.txis) begin
								res.tx_valid = 1'b1;
								res.tx_byte  = total_bytes_q;
							end else if (item_s1.tcr) begin
								phase_n         = PH_DATA;
								res.program_res = 1'b1;
								res.slave_out   = saved_slave_q;
								res.nbytes      = total_bytes_q;
								res.autoend     = 1'b1;
							end else begin
								res.finish_code = FIN_NAK;
								mode_n          = MODE_IDLE;
							end
						end
						PH_DATA: begin
							if (item_s1.txis) begin
								res.tx_valid  = 1'b1;
								res.tx_byte   = item_s1.data_byte;
								res.buf_valid = 1'b1;
								res.buf_index = byte_index_q;
								byte_index_n  = idx_inc;
								if (idx_inc >= total_bytes_q) begin
									res.finish_code = FIN_DONE;
									mode_n          = MODE_IDLE;
								end
							end else begin
								res.finish_code = FIN_NAK;
								mode_n          = MODE_IDLE;
							end
						end
						default: ;
					endcase
				end else if (mode_q == MODE_RX) begin
					case (phase_q)
						PH_ADDR: begin
							priority if (item_s1.txis) begin
								res.tx_valid = 1'b1;
								res.tx_byte  = saved_reg_addr_q;
							end else if (item_s1.tc) begin
								// repeated start, now in the read direction
								res.program_res = 1'b1;
								res.slave_out   = saved_slave_q;
								res.gen_start   = 1'b1;
								res.rd_wrn      = 1'b1;
								if (saved_use_len_q) begin
									phase_n     = PH_LEN;
									res.nbytes  = 8'd1;
									res.reload  = 1'b1;
								end else begin
									phase_n     = PH_DATA;
									res.nbytes  = total_bytes_q;
									res.autoend = 1'b1;
								end
							end else begin
								res.finish_code = FIN_NAK;
								mode_n          = MODE_IDLE;
							end
						end
						PH_LEN: begin
							if (item_s1.rxne) begin
								total_bytes_n   = item_s1.data_byte;
								phase_n         = PH_DATA;
								res.program_res = 1'b1;
								res.slave_out   = saved_slave_q;
								res.nbytes      = item_s1.data_byte;
								res.rd_wrn      = 1'b1;
								res.autoend     = 1'b1;
							end else begin
								res.finish_code = FIN_NAK;
								mode_n          = MODE_IDLE;
							end
						end
						PH_DATA: begin
							if (item_s1.rxne) begin
								res.buf_valid = 1'b1;
								res.buf_index = byte_index_q;
								byte_index_n  = idx_inc;
								if (idx_inc >= total_bytes_q) begin
									res.finish_code = FIN_DONE;
									mode_n          = MODE_IDLE;
								end
							end else begin
								res.finish_code = FIN_NAK;
								mode_n          = MODE_IDLE;
							end
						end
						default: ;
					endcase
				end else begin
					res.finish_code = FIN_INVALID;
					mode_n          = MODE_IDLE;
				end
			end
			default: ;
		endcase
	end

endmodule

### tb/imts_checker.sv
module imts_checker
	import imts_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	imts_in_if   req,
	imts_out_if  rsp,
	output int   mismatches,
	output int   outstanding
);

	// sequencer state as the block should hold it
	mode_t      seq_mode;
	phase_t     seq_phase;
	logic [7:0] byte_idx;
	logic [7:0] byte_total;
	logic [7:0] reg_byte;
	logic       len_phase_on;
	logic [6:0] slave_q;

	out_item_t  predicted_rsp[$];
	out_item_t  oldest_rsp;
	int         err_cnt = 0;

	assign mismatches = err_cnt;

	function automatic out_item_t program_word(input logic [7:0] nb, input logic rd,
			input logic rl, input logic ae, input logic st);
		out_item_t o;
		o = '0;
		o.program_res = 1'b1;
		o.nbytes = nb;
		o.rd_wrn = rd;
		o.reload = rl;
		o.autoend = ae;
		o.gen_start = st;
		o.slave_out = slave_q;
		return o;
	endfunction

	function automatic out_item_t predict_sequencer(input in_item_t it);
		out_item_t o;
		logic rd;
		o = '0;
		rd = (it.command == CMD_START_RD);
		if (it.command == CMD_START_RD || it.command == CMD_START_WR) begin
			if (seq_mode != MODE_IDLE) begin
				o.finish_code = FIN_BUSY;
			end else begin
				slave_q = it.slave_addr;
				reg_byte = it.reg_addr;
				len_phase_on = it.use_len;
				byte_total = it.length;
				byte_idx = '0;
				seq_mode = rd ? MODE_RX : MODE_TX;
				if (it.use_addr) begin
					seq_phase = PH_ADDR;
					o = program_word(8'd1, 1'b0, !rd, 1'b0, 1'b1);
				end else if (it.use_len) begin
					seq_phase = PH_LEN;
					o = program_word(8'd1, rd, 1'b1, 1'b0, 1'b1);
				end else begin
					seq_phase = PH_DATA;
					o = program_word(byte_total, rd, 1'b0, 1'b1, 1'b1);
				end
			end
		end else if (it.command == CMD_EVENT) begin
			if (it.bus_fault) begin
				o.finish_code = FIN_HW;
			end else if (seq_mode == MODE_TX) begin
				case (seq_phase)
				PH_ADDR: begin
					if (it.txis) begin
						o.tx_valid = 1'b1;
						o.tx_byte = reg_byte;
					end else if (it.tcr) begin
						// no repeated start on the write side
						if (len_phase_on) begin
							seq_phase = PH_LEN;
							o = program_word(8'd1, 1'b0, 1'b1, 1'b0, 1'b0);
						end else begin
							seq_phase = PH_DATA;
							o = program_word(byte_total, 1'b0, 1'b0, 1'b1, 1'b0);
						end
					end else begin
						o.finish_code = FIN_NAK;
					end
				end
				PH_LEN: begin
					if (it.txis) begin
						o.tx_valid = 1'b1;
						o.tx_byte = byte_total;
					end else if (it.tcr) begin
						seq_phase = PH_DATA;
						o = program_word(byte_total, 1'b0, 1'b0, 1'b1, 1'b0);
					end else begin
						o.finish_code = FIN_NAK;
					end
				end
				PH_DATA: begin
					if (it.txis) begin
						o.tx_valid = 1'b1;
						o.tx_byte = it.data_byte;
						o.buf_valid = 1'b1;
						o.buf_index = byte_idx;
						byte_idx = byte_idx + 8'd1;
						if (byte_idx >= byte_total)
							o.finish_code = FIN_DONE;
					end else begin
						o.finish_code = FIN_NAK;
					end
				end
				default: ;
				endcase
			end else if (seq_mode == MODE_RX) begin
				case (seq_phase)
				PH_ADDR: begin
					if (it.txis) begin
						o.tx_valid = 1'b1;
						o.tx_byte = reg_byte;
					end else if (it.tc) begin
						if (len_phase_on) begin
							seq_phase = PH_LEN;
							o = program_word(8'd1, 1'b1, 1'b1, 1'b0, 1'b1);
						end else begin
							seq_phase = PH_DATA;
							o = program_word(byte_total, 1'b1, 1'b0, 1'b1, 1'b1);
						end
					end else begin
						o.finish_code = FIN_NAK;
					end
				end
				PH_LEN: begin
					// read count comes from the received length byte
					if (it.rxne) begin
						byte_total = it.data_byte;
						seq_phase = PH_DATA;
						o = program_word(byte_total, 1'b1, 1'b0, 1'b1, 1'b0);
					end else begin
						o.finish_code = FIN_NAK;
					end
				end
				PH_DATA: begin
					if (it.rxne) begin
						o.buf_valid = 1'b1;
						o.buf_index = byte_idx;
						byte_idx = byte_idx + 8'd1;
						if (byte_idx >= byte_total)
							o.finish_code = FIN_DONE;
					end else begin
						o.finish_code = FIN_NAK;
					end
				end
				default: ;
				endcase
			end else begin
				o.finish_code = FIN_INVALID;
			end
			if (o.finish_code != FIN_NONE && o.finish_code != FIN_BUSY)
				seq_mode = MODE_IDLE;
		end
		return o;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_mode = MODE_IDLE;
			seq_phase = PH_ADDR;
			byte_idx = '0;
			byte_total = '0;
			reg_byte = '0;
			len_phase_on = 1'b0;
			slave_q = '0;
			predicted_rsp.delete();
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (predicted_rsp.size() == 0) begin
					$error("result transfer with no prediction pending");
					err_cnt++;
				end else begin
					oldest_rsp = predicted_rsp.pop_front();
					check_field("program_res", 8'(oldest_rsp.program_res),
						8'(rsp.data.program_res));
					check_field("nbytes", oldest_rsp.nbytes, rsp.data.nbytes);
					check_field("rd_wrn", 8'(oldest_rsp.rd_wrn), 8'(rsp.data.rd_wrn));
					check_field("reload", 8'(oldest_rsp.reload), 8'(rsp.data.reload));
					check_field("autoend", 8'(oldest_rsp.autoend), 8'(rsp.data.autoend));
					check_field("gen_start", 8'(oldest_rsp.gen_start),
						8'(rsp.data.gen_start));
					check_field("slave_out", 8'(oldest_rsp.slave_out),
						8'(rsp.data.slave_out));
					check_field("tx_valid", 8'(oldest_rsp.tx_valid), 8'(rsp.data.tx_valid));
					check_field("tx_byte", oldest_rsp.tx_byte, rsp.data.tx_byte);
					check_field("buf_valid", 8'(oldest_rsp.buf_valid),
						8'(rsp.data.buf_valid));
					check_field("buf_index", oldest_rsp.buf_index, rsp.data.buf_index);
					check_field("finish_code", 8'(oldest_rsp.finish_code),
						8'(rsp.data.finish_code));
				end
			end
			if (req.valid && req.ready)
				predicted_rsp.push_back(predict_sequencer(req.data));
			outstanding <= predicted_rsp.size();
		end
	end

endmodule

### tb/tb_top.sv
module tb_top;
	import imts_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam logic [1:0]  CMD_IGNORED = 2'd3;
	localparam int          HOLD_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	imts_in_if  req();
	imts_out_if rsp();

	int mismatches;
	int outstanding;

	int src_idle_pct = 0;
	int rsp_stall_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int items_sent = 0;
	int big_left = 2;
	int unsigned cycle_cnt = 0;

	int src_pct_tbl[4] = '{0, 88, 0, 33};
	int rsp_pct_tbl[4] = '{0, 0, 88, 33};
	int target_tbl[4] = '{250, 475, 700, 925};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	i2c_master_transaction_sequencer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	imts_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// result side: random stalls, plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_requests != holds_served) begin
			holds_served <= holds_served + 1;
			hold_left <= HOLD_CYCLES;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
		end
	end

	function automatic in_item_t random_item();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[$bits(in_item_t)-1:0];
	endfunction

	function automatic in_item_t event_item();
		in_item_t it;
		it = random_item();
		it.command = CMD_EVENT;
		it.bus_fault = 1'b0;
		return it;
	endfunction

	function automatic in_item_t start_item(input logic [1:0] cmd, input logic [6:0] slave,
			input logic with_addr, input logic with_len, input logic [7:0] reg_a,
			input logic [7:0] count);
		in_item_t it;
		it = '0;
		it.command = cmd;
		it.slave_addr = slave;
		it.use_addr = with_addr;
		it.use_len = with_len;
		it.reg_addr = reg_a;
		it.length = count;
		return it;
	endfunction

	function automatic in_item_t flag_item(input logic txis, input logic tc, input logic tcr,
			input logic rxne, input logic fault, input logic [7:0] d);
		in_item_t it;
		it = '0;
		it.command = CMD_EVENT;
		it.txis = txis;
		it.tc = tc;
		it.tcr = tcr;
		it.rxne = rxne;
		it.bus_fault = fault;
		it.data_byte = d;
		return it;
	endfunction

	task automatic send(input in_item_t it);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= it;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// sender pauses until every predicted result has been taken
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic run_transfer(input logic rd, input logic with_addr, input logic with_len,
			input logic [7:0] count, input int break_pct);
		in_item_t it;
		in_item_t plan[$];
		int n;
		it = random_item();
		it.command = rd ? CMD_START_RD : CMD_START_WR;
		it.use_addr = with_addr;
		it.use_len = with_len;
		// a read with a length byte takes its count from the bus instead
		if (!(rd && with_len))
			it.length = count;
		plan.push_back(it);
		if (with_addr) begin
			it = event_item();
			it.txis = 1'b1;
			plan.push_back(it);
			it = event_item();
			it.txis = 1'b0;
			if (rd)
				it.tc = 1'b1;
			else
				it.tcr = 1'b1;
			plan.push_back(it);
		end
		if (with_len) begin
			if (rd) begin
				it = event_item();
				it.rxne = 1'b1;
				it.data_byte = count;
				plan.push_back(it);
			end else begin
				it = event_item();
				it.txis = 1'b1;
				plan.push_back(it);
				it = event_item();
				it.txis = 1'b0;
				it.tcr = 1'b1;
				plan.push_back(it);
			end
		end
		n = (count == 8'd0) ? 1 : int'(count);
		repeat (n) begin
			it = event_item();
			if (rd)
				it.rxne = 1'b1;
			else
				it.txis = 1'b1;
			plan.push_back(it);
		end
		send(plan.pop_front());
		while (plan.size() > 0) begin
			if ($urandom_range(0, 99) < break_pct) begin
				it = random_item();
				case ($urandom_range(0, 3))
				0: begin
					it.command = CMD_EVENT;
					it.bus_fault = 1'b1;
					send(it);
					return;
				end
				1: begin
					it = event_item();
					it.txis = 1'b0;
					it.tc = 1'b0;
					it.tcr = 1'b0;
					it.rxne = 1'b0;
					send(it);
					return;
				end
				2: begin
					it.command = $urandom_range(0, 1) ? CMD_START_WR : CMD_START_RD;
					send(it);
				end
				default: begin
					it.command = CMD_IGNORED;
					send(it);
				end
				endcase
			end
			send(plan.pop_front());
		end
	endtask

	task automatic random_phase(input int target);
		in_item_t it;
		logic [7:0] count;
		while (items_sent < target) begin
			if ($urandom_range(0, 99) < 80) begin
				// mostly short transfers, a couple of long ones
				if (big_left > 0 && $urandom_range(0, 99) < 4) begin
					count = (big_left == 2) ? 8'hff : 8'($urandom_range(128, 254));
					big_left--;
				end else begin
					count = 8'($urandom_range(0, 7));
				end
				run_transfer(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), count, (count > 8'd7) ? 0 : 6);
			end else begin
				repeat ($urandom_range(1, 3)) begin
					it = random_item();
					if ($urandom_range(0, 3) != 0)
						it.command = $urandom_range(0, 1) ? CMD_EVENT : CMD_IGNORED;
					send(it);
				end
			end
		end
	endtask

	task automatic directed();
		in_item_t it;
		send(flag_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
		send(flag_item(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'hff));
		it = '1;
		it.command = CMD_IGNORED;
		send(it);
		// write with address and length phases
		send(start_item(CMD_START_WR, 7'h7f, 1'b1, 1'b1, 8'hff, 8'd2));
		send(flag_item(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
		send(start_item(CMD_START_RD, 7'h11, 1'b0, 1'b0, 8'h22, 8'd3));
		send(flag_item(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
		send(flag_item(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
		send(flag_item(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
		send(flag_item(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'hff));
		send(flag_item(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
		// read, received length byte of zero
		send(start_item(CMD_START_RD, 7'h00, 1'b1, 1'b1, 8'h00, 8'hff));
		send(flag_item(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
		send(flag_item(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
		send(flag_item(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
		send(flag_item(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'ha5));
		send(start_item(CMD_START_RD, 7'h55, 1'b0, 1'b0, 8'h5a, 8'd1));
		send(flag_item(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'hff));
		// zero count write completes on first data event
		send(start_item(CMD_START_WR, 7'h2a, 1'b0, 1'b0, 8'h00, 8'd0));
		send(flag_item(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h3c));
		send(start_item(CMD_START_RD, 7'h01, 1'b0, 1'b1, 8'h00, 8'h80));
		send(flag_item(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd1));
		send(flag_item(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
		send(start_item(CMD_START_WR, 7'h40, 1'b0, 1'b1, 8'h81, 8'd5));
		send(flag_item(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00));
		// fault wins over every other flag
		send(start_item(CMD_START_RD, 7'h3f, 1'b1, 1'b0, 8'h7e, 8'd4));
		send(flag_item(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'h99));
	endtask

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		req.valid = 1'b0;
		req.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed();
		drain();
		for (int p = 0; p < 4; p++) begin
			src_idle_pct = src_pct_tbl[p];
			rsp_stall_pct = rsp_pct_tbl[p];
			if (p == 0)
				hold_requests <= hold_requests + 1;
			random_phase(target_tbl[p]);
			drain();
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### files.f
sv/imts_pkg.sv
sv/imts_if.sv
sv/i2c_master_transaction_sequencer.sv
tb/imts_checker.sv
tb/tb_top.sv
